// ===== hw/rtl/wsp_pkg.sv =====
package wsp_pkg;

   // Field widths of the two channels
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned CodeWidth   = 2;
   localparam int unsigned HalfWidth   = 16;
   localparam int unsigned WordWidth   = 32;

   // Parser phases
   typedef enum logic [4:0] {
      PH_RIFF  = 5'd0,
      PH_RSIZE = 5'd1,
      PH_WAVE  = 5'd2,
      PH_FMT   = 5'd3,
      PH_FSIZE = 5'd4,
      PH_FMTID = 5'd5,
      PH_CHANS = 5'd6,
      PH_RATE  = 5'd7,
      PH_BRATE = 5'd8,
      PH_BLK   = 5'd9,
      PH_BITS  = 5'd10,
      PH_LOOK  = 5'd11,
      PH_SKIP  = 5'd12,
      PH_DTAG  = 5'd13,
      PH_DSIZE = 5'd14,
      PH_SAMP  = 5'd15,
      PH_PAD   = 5'd16,
      PH_DONE  = 5'd17
   } phase_type;

   // Result kinds
   typedef enum logic [KindWidth-1:0] {
      EV_HEADER = 2'd0,
      EV_SAMPLE = 2'd1,
      EV_ERROR  = 2'd2
   } event_type;

   // Error codes
   typedef enum logic [CodeWidth-1:0] {
      ERR_OK     = 2'd0,
      ERR_FORMAT = 2'd1,
      ERR_UNSUPP = 2'd2
   } error_type;

   // Chunk tags, first character in the low byte
   typedef enum logic [1:0] {
      TAG_SEL_RIFF = 2'd0,
      TAG_SEL_WAVE = 2'd1,
      TAG_SEL_FMT  = 2'd2,
      TAG_SEL_DATA = 2'd3
   } tag_sel_type;

   localparam logic [WordWidth-1:0] TagRiff = 32'h4646_4952;
   localparam logic [WordWidth-1:0] TagWave = 32'h4556_4157;
   localparam logic [WordWidth-1:0] TagFmt  = 32'h2074_6d66;
   localparam logic [WordWidth-1:0] TagData = 32'h6174_6164;

   localparam logic [ByteWidth-1:0] CharD = 8'h64;
   localparam logic [ByteWidth-1:0] CharA = 8'h61;

   // Expected tag character at a byte position
   function automatic logic [ByteWidth-1:0] tag_char(input tag_sel_type sel,
                                                     input logic [1:0]  pos);
      logic [WordWidth-1:0] word;
      unique case (sel)
         TAG_SEL_RIFF: word = TagRiff;
         TAG_SEL_WAVE: word = TagWave;
         TAG_SEL_FMT:  word = TagFmt;
         TAG_SEL_DATA: word = TagData;
         default:      word = TagData;
      endcase
      tag_char = word[{pos, 3'b000} +: ByteWidth];
   endfunction

   // One result word
   typedef struct packed {
      event_type              event_kind;
      error_type              error_code;
      logic                   channel_index;
      logic [HalfWidth-1:0]   sample_value;
      logic                   last_sample;
      logic [HalfWidth-1:0]   format_id;
      logic [HalfWidth-1:0]   channel_count;
      logic [WordWidth-1:0]   sample_rate;
      logic [WordWidth-1:0]   byte_rate;
      logic [HalfWidth-1:0]   block_align;
      logic [HalfWidth-1:0]   bits_per_sample;
      logic [WordWidth-1:0]   data_size;
   } rsp_word_type;

endpackage

// ===== hw/rtl/wsp_req_if.sv =====
interface wsp_req_if import wsp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] data_byte;
   logic                 restart;

   modport source (output valid, data_byte, restart, input ready);
   modport sink   (input valid, data_byte, restart, output ready);
endinterface

// ===== hw/rtl/wsp_rsp_if.sv =====
interface wsp_rsp_if import wsp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [KindWidth-1:0]        event_kind;
   logic [CodeWidth-1:0]        error_code;
   logic                        channel_index;
   logic signed [HalfWidth-1:0] sample_value;
   logic                        last_sample;
   logic [HalfWidth-1:0]        format_id;
   logic [HalfWidth-1:0]        channel_count;
   logic [WordWidth-1:0]        sample_rate;
   logic [WordWidth-1:0]        byte_rate;
   logic [HalfWidth-1:0]        block_align;
   logic [HalfWidth-1:0]        bits_per_sample;
   logic [WordWidth-1:0]        data_size;

   modport source (output valid, event_kind, error_code, channel_index, sample_value,
                   last_sample, format_id, channel_count, sample_rate, byte_rate,
                   block_align, bits_per_sample, data_size,
                   input ready);
   modport sink   (input valid, event_kind, error_code, channel_index, sample_value,
                   last_sample, format_id, channel_count, sample_rate, byte_rate,
                   block_align, bits_per_sample, data_size,
                   output ready);
endinterface

// ===== hw/rtl/wav_stream_parser_unit.sv =====
// Channel   Dir  Word                        Handshake
// req_if    in   data_byte, restart           valid/ready
// rsp_if    out  event, error, sample, header valid/ready
//
// One byte is taken per cycle; a result, if the byte makes one, is in the
// output register on the next cycle. Parser state and result register are one
// stage apart, so a byte is taken whenever that register is empty or being
// drained. Reset is synchronous and returns the parser to the RIFF tag; a byte
// with restart set does the same before it is parsed. A stalled result holds
// the input side only while it waits.
module wav_stream_parser_unit
   import wsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   wsp_req_if.sink   req_if,
   wsp_rsp_if.source rsp_if
);

   // Parser state
   phase_type            phase_ff, phase_in;
   logic [1:0]           pos_ff, pos_in;
   logic [WordWidth-1:0] field_ff, field_in;
   logic [WordWidth-1:0] look_ff, look_in;
   logic [HalfWidth-1:0] skip_ff, skip_in;
   logic [WordWidth-1:0] data_ff, data_in;
   logic                 chan_ff, chan_in;
   logic [ByteWidth-1:0] hold_ff, hold_in;

   // Format fields
   logic [HalfWidth-1:0] fmt_id_ff, fmt_id_in;
   logic [HalfWidth-1:0] chans_ff, chans_in;
   logic [WordWidth-1:0] rate_ff, rate_in;
   logic [WordWidth-1:0] brate_ff, brate_in;
   logic [HalfWidth-1:0] blk_ff, blk_in;
   logic [HalfWidth-1:0] bits_ff, bits_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 emit;

   // Handshake
   logic                 req_fire;
   logic [ByteWidth-1:0] b;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign b            = req_if.data_byte;

   // State as seen by this byte, after a restart
   phase_type            phase_cur;
   logic [1:0]           pos_cur;
   logic [WordWidth-1:0] field_cur;
   logic [WordWidth-1:0] look_cur;

   assign phase_cur = req_if.restart ? PH_RIFF : phase_ff;
   assign pos_cur   = req_if.restart ? 2'd0 : pos_ff;
   assign field_cur = req_if.restart ? '0 : field_ff;
   assign look_cur  = req_if.restart ? '0 : look_ff;

   // Shared decode
   tag_sel_type          tag_sel;
   logic                 tag_miss;
   logic                 pos_last;
   logic                 field_last;
   logic [WordWidth-1:0] field_acc;
   logic [WordWidth-1:0] look_acc;
   logic [HalfWidth-1:0] look_len;
   logic                 look_is_data;
   logic                 look_short_bad;
   logic                 ss_two;
   logic                 fmt_ok;
   logic [WordWidth-1:0] data_src;
   logic [WordWidth:0]   data_diff;
   logic                 data_lt;
   logic [HalfWidth-1:0] skip_dec;
   logic                 samp_emit;
   logic                 chan_last;
   logic [HalfWidth-1:0] samp_val;

   always_comb begin
      unique case (phase_cur)
         PH_RIFF: tag_sel = TAG_SEL_RIFF;
         PH_WAVE: tag_sel = TAG_SEL_WAVE;
         PH_FMT:  tag_sel = TAG_SEL_FMT;
         default: tag_sel = TAG_SEL_DATA;
      endcase
   end

   assign tag_miss = b != tag_char(tag_sel, pos_cur);
   assign pos_last = pos_cur == 2'd3;

   // Two-byte fields end at position one, four-byte fields at three
   always_comb begin
      unique case (phase_cur) inside
         PH_FMTID, PH_CHANS, PH_BLK, PH_BITS: field_last = pos_cur == 2'd1;
         default:                             field_last = pos_last;
      endcase
   end

   assign field_acc = field_cur | ({{(WordWidth-ByteWidth){1'b0}}, b} << {pos_cur, 3'b000});
   assign look_acc  = look_cur | ({{(WordWidth-ByteWidth){1'b0}}, b} << {pos_cur, 3'b000});
   assign look_len  = look_acc[HalfWidth-1:0];
   assign look_is_data = look_acc == TagData;
   // Extension length zero: the last two look-ahead bytes must open the data tag
   assign look_short_bad = look_acc[23:16] != CharD || b != CharA;

   // Bytes per sample is two: mono block of two, or stereo block of four or five
   assign ss_two = (chans_ff == 16'd1) ? (blk_ff == 16'd2) : (blk_ff[15:1] == 15'd2);
   assign fmt_ok = (chans_ff == 16'd1) ? (blk_ff == 16'd1 || blk_ff == 16'd2) :
                   (chans_ff == 16'd2) ? (blk_ff[15:1] == 15'd1 || blk_ff[15:1] == 15'd2) :
                   1'b0;

   // Remaining data against one frame; the borrow is the compare
   assign data_src  = (phase_cur == PH_DSIZE) ? field_acc : data_ff;
   assign data_diff = {1'b0, data_src} - {{(WordWidth-HalfWidth+1){1'b0}}, blk_ff};
   assign data_lt   = data_diff[WordWidth];
   assign skip_dec  = skip_ff - 16'd1;

   assign samp_emit = !(ss_two && pos_cur == 2'd0);
   assign chan_last = chans_ff == 16'd1 || chan_ff;
   assign samp_val  = ss_two ? {b, hold_ff} : {{8{~b[7]}}, ~b[7], b[6:0]};

   // Next phase
   always_comb begin
      phase_in = phase_cur;
      unique case (phase_cur)
         PH_RIFF, PH_WAVE, PH_FMT, PH_DTAG: begin
            if (tag_miss) begin
               phase_in = PH_DONE;
            end else if (pos_last) begin
               unique case (phase_cur)
                  PH_RIFF: phase_in = PH_RSIZE;
                  PH_WAVE: phase_in = PH_FMT;
                  PH_FMT:  phase_in = PH_FSIZE;
                  default: phase_in = PH_DSIZE;
               endcase
            end
         end
         PH_RSIZE, PH_FSIZE, PH_FMTID, PH_CHANS, PH_RATE, PH_BRATE, PH_BLK, PH_BITS: begin
            if (field_last) begin
               phase_in = phase_type'(phase_cur + 5'd1);
            end
         end
         PH_LOOK: begin
            if (pos_last) begin
               if (look_is_data) begin
                  phase_in = PH_DSIZE;
               end else if (look_len >= 16'd2) begin
                  phase_in = (look_len == 16'd2) ? PH_DTAG : PH_SKIP;
               end else if (look_len == 16'd1) begin
                  phase_in = (b != CharD) ? PH_DONE : PH_DTAG;
               end else begin
                  phase_in = look_short_bad ? PH_DONE : PH_DTAG;
               end
            end
         end
         PH_SKIP: begin
            if (skip_dec == '0) begin
               phase_in = PH_DTAG;
            end
         end
         PH_DSIZE: begin
            if (field_last) begin
               phase_in = (!fmt_ok || data_lt) ? PH_DONE : PH_SAMP;
            end
         end
         PH_SAMP: begin
            if (samp_emit && chan_last) begin
               if (data_lt) begin
                  phase_in = PH_DONE;
               end else if (skip_dec != '0) begin
                  phase_in = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            if (skip_dec == '0) begin
               phase_in = data_lt ? PH_DONE : PH_SAMP;
            end
         end
         default: phase_in = PH_DONE;
      endcase
   end

   // Datapath and result
   always_comb begin
      pos_in    = pos_cur;
      field_in  = field_cur;
      look_in   = look_cur;
      skip_in   = skip_ff;
      data_in   = data_ff;
      chan_in   = req_if.restart ? 1'b0 : chan_ff;
      hold_in   = hold_ff;
      fmt_id_in = fmt_id_ff;
      chans_in  = chans_ff;
      rate_in   = rate_ff;
      brate_in  = brate_ff;
      blk_in    = blk_ff;
      bits_in   = bits_ff;
      emit      = 1'b0;
      rsp_in    = '0;

      unique case (phase_cur)
         PH_RIFF, PH_WAVE, PH_FMT, PH_DTAG: begin
            if (tag_miss) begin
               emit              = 1'b1;
               rsp_in.event_kind = EV_ERROR;
               rsp_in.error_code = ERR_FORMAT;
            end else begin
               pos_in = pos_cur + 2'd1;
            end
         end
         PH_RSIZE, PH_FSIZE, PH_FMTID, PH_CHANS, PH_RATE, PH_BRATE, PH_BLK, PH_BITS: begin
            field_in = field_acc;
            pos_in   = pos_cur + 2'd1;
            if (field_last) begin
               pos_in   = 2'd0;
               field_in = '0;
               unique case (phase_cur)
                  PH_FMTID: fmt_id_in = field_acc[HalfWidth-1:0];
                  PH_CHANS: chans_in  = field_acc[HalfWidth-1:0];
                  PH_RATE:  rate_in   = field_acc;
                  PH_BRATE: brate_in  = field_acc;
                  PH_BLK:   blk_in    = field_acc[HalfWidth-1:0];
                  PH_BITS:  bits_in   = field_acc[HalfWidth-1:0];
                  default:  ;
               endcase
            end
         end
         PH_LOOK: begin
            look_in = look_acc;
            pos_in  = pos_cur + 2'd1;
            if (pos_last && !look_is_data) begin
               if (look_len >= 16'd2) begin
                  skip_in = look_len - 16'd2;
               end else if (look_len == 16'd1) begin
                  pos_in = 2'd1;
                  if (b != CharD) begin
                     emit              = 1'b1;
                     rsp_in.event_kind = EV_ERROR;
                     rsp_in.error_code = ERR_FORMAT;
                  end
               end else begin
                  pos_in = 2'd2;
                  if (look_short_bad) begin
                     emit              = 1'b1;
                     rsp_in.event_kind = EV_ERROR;
                     rsp_in.error_code = ERR_FORMAT;
                  end
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               pos_in = 2'd0;
            end
         end
         PH_DSIZE: begin
            field_in = field_acc;
            pos_in   = pos_cur + 2'd1;
            if (field_last) begin
               pos_in   = 2'd0;
               field_in = '0;
               data_in  = field_acc;
               emit     = 1'b1;
               if (!fmt_ok) begin
                  rsp_in.event_kind = EV_ERROR;
                  rsp_in.error_code = ERR_UNSUPP;
               end else begin
                  rsp_in.event_kind      = EV_HEADER;
                  rsp_in.format_id       = fmt_id_ff;
                  rsp_in.channel_count   = chans_ff;
                  rsp_in.sample_rate     = rate_ff;
                  rsp_in.byte_rate       = brate_ff;
                  rsp_in.block_align     = blk_ff;
                  rsp_in.bits_per_sample = bits_ff;
                  rsp_in.data_size       = field_acc;
                  if (!data_lt) begin
                     data_in = data_diff[WordWidth-1:0];
                     skip_in = blk_ff;
                     chan_in = 1'b0;
                  end
               end
            end
         end
         PH_SAMP: begin
            skip_in = skip_dec;
            if (!samp_emit) begin
               hold_in = b;
               pos_in  = 2'd1;
            end else begin
               pos_in               = 2'd0;
               emit                 = 1'b1;
               rsp_in.event_kind    = EV_SAMPLE;
               rsp_in.channel_index = chan_ff;
               rsp_in.sample_value  = samp_val;
               rsp_in.last_sample   = chan_last && data_lt;
               if (!chan_last) begin
                  chan_in = 1'b1;
               end else if (!data_lt && skip_dec == '0) begin
                  data_in = data_diff[WordWidth-1:0];
                  skip_in = blk_ff;
                  chan_in = 1'b0;
               end
            end
         end
         PH_PAD: begin
            skip_in = skip_dec;
            if (skip_dec == '0 && !data_lt) begin
               data_in = data_diff[WordWidth-1:0];
               skip_in = blk_ff;
               chan_in = 1'b0;
               pos_in  = 2'd0;
            end
         end
         default: ;
      endcase
   end

   // Result valid: set by a producing byte, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         pos_ff       <= 2'd0;
         field_ff     <= '0;
         look_ff      <= '0;
         chan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            field_ff <= field_in;
            look_ff  <= look_in;
            chan_ff  <= chan_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         skip_ff   <= skip_in;
         data_ff   <= data_in;
         hold_ff   <= hold_in;
         fmt_id_ff <= fmt_id_in;
         chans_ff  <= chans_in;
         rate_ff   <= rate_in;
         brate_ff  <= brate_in;
         blk_ff    <= blk_in;
         bits_ff   <= bits_in;
         if (emit) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   // Output channel
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.event_kind      = rsp_ff.event_kind;
   assign rsp_if.error_code      = rsp_ff.error_code;
   assign rsp_if.channel_index   = rsp_ff.channel_index;
   assign rsp_if.sample_value    = rsp_ff.sample_value;
   assign rsp_if.last_sample     = rsp_ff.last_sample;
   assign rsp_if.format_id       = rsp_ff.format_id;
   assign rsp_if.channel_count   = rsp_ff.channel_count;
   assign rsp_if.sample_rate     = rsp_ff.sample_rate;
   assign rsp_if.byte_rate       = rsp_ff.byte_rate;
   assign rsp_if.block_align     = rsp_ff.block_align;
   assign rsp_if.bits_per_sample = rsp_ff.bits_per_sample;
   assign rsp_if.data_size       = rsp_ff.data_size;

`ifndef SYNTHESIS
   // An error result always ends the parse
   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit && rsp_in.event_kind == EV_ERROR) |=> phase_ff == PH_DONE)
      else $error("error result without end of parse");

   // The final sample always ends the parse
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit && rsp_in.last_sample) |=> phase_ff == PH_DONE)
      else $error("last sample without end of parse");

   // Samples are only decoded for a supported channel count
   a_samp_chans: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SAMP) |-> (chans_ff == 16'd1 || chans_ff == 16'd2))
      else $error("sample phase with unsupported channel count");

   // A result held in the register blocks the input only while not taken
   a_ready_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("byte taken while result stalled");
`endif

endmodule

// ===== bench/wav_stream_parser_unit_check.sv =====
module wav_stream_parser_unit_check
   import wsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wsp_req_if   req_mon,
   wsp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PrintCap = 40;

   // Parser copy
   phase_type            phase;
   logic [1:0]           pos;
   logic [WordWidth-1:0] shift;
   logic [WordWidth-1:0] look;
   logic [WordWidth-1:0] fmt_word [6];
   logic [HalfWidth-1:0] skip_left;
   logic [WordWidth-1:0] data_left;
   logic                 chan;
   logic [ByteWidth-1:0] low_hold;

   rsp_word_type expected_events [$];
   int           mismatch_count = 0;

   task automatic clear_parser();
      phase     = PH_RIFF;
      pos       = '0;
      shift     = '0;
      look      = '0;
      skip_left = '0;
      data_left = '0;
      chan      = 1'b0;
      low_hold  = '0;
      for (int i = 0; i < 6; i++) fmt_word[i] = '0;
   endtask

   task automatic push_event(input event_type kind, input error_type code, input logic c,
                             input logic [HalfWidth-1:0] val, input logic is_last,
                             input bit hdr);
      rsp_word_type ev;
      ev               = '0;
      ev.event_kind    = kind;
      ev.error_code    = code;
      ev.channel_index = c;
      ev.sample_value  = val;
      ev.last_sample   = is_last;
      if (hdr) begin
         ev.format_id       = fmt_word[0][HalfWidth-1:0];
         ev.channel_count   = fmt_word[1][HalfWidth-1:0];
         ev.sample_rate     = fmt_word[2];
         ev.byte_rate       = fmt_word[3];
         ev.block_align     = fmt_word[4][HalfWidth-1:0];
         ev.bits_per_sample = fmt_word[5][HalfWidth-1:0];
         ev.data_size       = data_left;
      end
      expected_events.push_back(ev);
   endtask

   task automatic abort_parse(input error_type code);
      phase = PH_DONE;
      push_event(EV_ERROR, code, 1'b0, '0, 1'b0, 1'b0);
   endtask

   // little-endian field assembly, done on the last byte
   task automatic take_field(input logic [ByteWidth-1:0] b, input int len, output bit done);
      shift = shift | (32'(b) << (8 * pos));
      if (int'(pos) + 1 >= len) begin
         pos  = '0;
         done = 1'b1;
      end else begin
         pos  = pos + 2'd1;
         done = 1'b0;
      end
   endtask

   task automatic start_frame();
      skip_left = fmt_word[4][HalfWidth-1:0];
      chan      = 1'b0;
      pos       = '0;
      phase     = PH_SAMP;
   endtask

   // next frame, or the end once fewer than a block of bytes remain
   task automatic end_frame();
      if (data_left < 32'(fmt_word[4][HalfWidth-1:0])) begin
         phase = PH_DONE;
      end else begin
         data_left = data_left - 32'(fmt_word[4][HalfWidth-1:0]);
         start_frame();
      end
   endtask

   // One accepted input word through the parser
   task automatic parse_byte(input logic [ByteWidth-1:0] b, input logic restart);
      logic [WordWidth-1:0] word;
      logic [HalfWidth-1:0] ch;
      logic [HalfWidth-1:0] blk;
      logic [HalfWidth-1:0] ext_len;
      logic [HalfWidth-1:0] val;
      int unsigned          ss;
      int                   k;
      bit                   done;
      logic                 c;
      logic                 is_last;
      if (restart) clear_parser();
      ch  = fmt_word[1][HalfWidth-1:0];
      blk = fmt_word[4][HalfWidth-1:0];
      case (phase)
         PH_RIFF, PH_WAVE, PH_FMT, PH_DTAG: begin
            case (phase)
               PH_RIFF: word = TagRiff;
               PH_WAVE: word = TagWave;
               PH_FMT:  word = TagFmt;
               default: word = TagData;
            endcase
            word = word >> (8 * pos);
            if (b != word[ByteWidth-1:0]) begin
               abort_parse(ERR_FORMAT);
            end else if (pos == 2'd3) begin
               pos   = '0;
               phase = (phase == PH_DTAG) ? PH_DSIZE : phase_type'(phase + 1);
            end else begin
               pos = pos + 2'd1;
            end
         end
         // lengths that are read and dropped
         PH_RSIZE, PH_FSIZE: begin
            take_field(b, 4, done);
            if (done) begin
               shift = '0;
               phase = phase_type'(phase + 1);
            end
         end
         PH_FMTID, PH_CHANS, PH_RATE, PH_BRATE, PH_BLK, PH_BITS: begin
            k = int'(phase) - int'(PH_FMTID);
            take_field(b, (k == 2 || k == 3) ? 4 : 2, done);
            if (done) begin
               fmt_word[k] = shift;
               shift       = '0;
               phase       = phase_type'(phase + 1);
            end
         end
         // four bytes ahead: data tag, or extension length and its first bytes
         PH_LOOK: begin
            look = look | (32'(b) << (8 * pos));
            if (pos != 2'd3) begin
               pos = pos + 2'd1;
            end else begin
               pos = '0;
               ext_len = look[15:0];
               if (look == TagData) begin
                  phase = PH_DSIZE;
               end else if (ext_len >= 16'd2) begin
                  skip_left = ext_len - 16'd2;
                  phase     = (skip_left == '0) ? PH_DTAG : PH_SKIP;
               end else if (ext_len == 16'd1) begin
                  if (look[31:24] != CharD) begin
                     abort_parse(ERR_FORMAT);
                  end else begin
                     phase = PH_DTAG;
                     pos   = 2'd1;
                  end
               end else if (look[23:16] != CharD || look[31:24] != CharA) begin
                  abort_parse(ERR_FORMAT);
               end else begin
                  phase = PH_DTAG;
                  pos   = 2'd2;
               end
            end
         end
         PH_SKIP: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == '0) begin
               phase = PH_DTAG;
               pos   = '0;
            end
         end
         // data size, then header or unsupported format
         PH_DSIZE: begin
            take_field(b, 4, done);
            if (done) begin
               data_left = shift;
               shift     = '0;
               if (ch != 16'd1 && ch != 16'd2) begin
                  abort_parse(ERR_UNSUPP);
               end else begin
                  ss = int'(blk) / int'(ch);
                  if (ss != 1 && ss != 2) begin
                     abort_parse(ERR_UNSUPP);
                  end else begin
                     push_event(EV_HEADER, ERR_OK, 1'b0, '0, 1'b0, 1'b1);
                     end_frame();
                  end
               end
            end
         end
         PH_SAMP: begin
            ss        = (ch != '0) ? int'(blk) / int'(ch) : 0;
            skip_left = skip_left - 16'd1;
            if (ss == 2 && pos == 2'd0) begin
               low_hold = b;
               pos      = 2'd1;
            end else begin
               if (ss == 2) begin
                  pos = '0;
                  val = {b, low_hold};
               end else begin
                  val = {8'h00, b} - 16'd128;
               end
               c       = chan;
               is_last = 1'b0;
               if (32'(c) + 1 >= 32'(ch)) begin
                  if (data_left < 32'(blk)) begin
                     is_last = 1'b1;
                     phase   = PH_DONE;
                  end else if (skip_left == '0) begin
                     data_left = data_left - 32'(blk);
                     start_frame();
                  end else begin
                     phase = PH_PAD;
                  end
               end else begin
                  chan = 1'b1;
               end
               push_event(EV_SAMPLE, ERR_OK, c, val, is_last, 1'b0);
            end
         end
         // padding at the end of a frame
         PH_PAD: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == '0) end_frame();
         end
         default: phase = PH_DONE;
      endcase
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < PrintCap) $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [WordWidth-1:0] got,
                              input logic [WordWidth-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Compare one result word with the oldest expectation
   task automatic compare_event();
      rsp_word_type want;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("result kind %0d with nothing expected",
                                   rsp_mon.event_kind));
      end else begin
         want = expected_events.pop_front();
         check_field("event_kind",      rsp_mon.event_kind,      want.event_kind);
         check_field("error_code",      rsp_mon.error_code,      want.error_code);
         check_field("channel_index",   rsp_mon.channel_index,   want.channel_index);
         check_field("sample_value",    unsigned'(rsp_mon.sample_value), want.sample_value);
         check_field("last_sample",     rsp_mon.last_sample,     want.last_sample);
         check_field("format_id",       rsp_mon.format_id,       want.format_id);
         check_field("channel_count",   rsp_mon.channel_count,   want.channel_count);
         check_field("sample_rate",     rsp_mon.sample_rate,     want.sample_rate);
         check_field("byte_rate",       rsp_mon.byte_rate,       want.byte_rate);
         check_field("block_align",     rsp_mon.block_align,     want.block_align);
         check_field("bits_per_sample", rsp_mon.bits_per_sample, want.bits_per_sample);
         check_field("data_size",       rsp_mon.data_size,       want.data_size);
      end
   endtask

   // Watch both channels; results are compared before the new word is parsed
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_events.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) compare_event();
         if (req_mon.valid && req_mon.ready) parse_byte(req_mon.data_byte, req_mon.restart);
      end
      pending_count <= expected_events.size();
      fail_count    <= mismatch_count;
   end

endmodule

// ===== bench/wav_stream_parser_unit_test.sv =====
module wav_stream_parser_unit_test
   import wsp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBytes = 750;
   localparam int DataCap     = 48;
   localparam int HoldStart   = 600;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 16;
   localparam int CycleLimit  = 400000;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   bit   calm;

   logic [ByteWidth-1:0] file_bytes [$];

   wsp_req_if req_if ();
   wsp_rsp_if rsp_if ();

   wav_stream_parser_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   wav_stream_parser_unit_check result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int unsigned r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WordWidth-1:0] extreme_word();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ByteWidth-1:0] sample_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return 8'h80;
         3:       return 8'h7f;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_le(input logic [WordWidth-1:0] v, input int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   // One WAV file, mostly well formed, some with bad formats or damage
   task automatic build_wav();
      int unsigned          ch;
      int unsigned          blk;
      int unsigned          ext_len;
      int unsigned          r;
      int unsigned          n;
      int unsigned          cut;
      logic [WordWidth-1:0] dsize;
      file_bytes.delete();
      r = $urandom_range(99);
      if (r < 80) begin
         ch  = $urandom_range(1, 2);
         blk = ch * $urandom_range(1, 2) + (($urandom_range(3) == 0) ? 1 : 0);
      end else if (r < 87) begin
         ch  = $urandom_range(1) ? 0 : $urandom_range(3, 65535);
         blk = $urandom_range(1, 4);
      end else if (r < 94) begin
         ch  = $urandom_range(1, 2);
         blk = $urandom_range(1) ? 0 : ch * $urandom_range(3, 5);
      end else begin
         ch  = $urandom_range(1, 2);
         blk = $urandom_range(65535);
      end
      push_le(TagRiff, 4);
      push_le(extreme_word(), 4);
      push_le(TagWave, 4);
      push_le(TagFmt, 4);
      push_le($urandom_range(1) ? 32'd16 : extreme_word(), 4);
      push_le($urandom_range(1) ? 32'd1 : extreme_word(), 2);
      push_le(ch, 2);
      push_le(extreme_word(), 4);
      push_le(extreme_word(), 4);
      push_le(blk, 2);
      push_le(extreme_word(), 2);
      // optional extension ahead of the data tag, short ones favoured
      r = $urandom_range(9);
      if (r >= 4) begin
         case (r)
            4:       ext_len = 0;
            5:       ext_len = 1;
            6:       ext_len = 2;
            7:       ext_len = 3;
            default: ext_len = $urandom_range(4, 12);
         endcase
         push_le(ext_len, 2);
         repeat (ext_len) file_bytes.push_back(8'($urandom));
      end
      push_le(TagData, 4);
      r = $urandom_range(19);
      if (blk == 0) dsize = $urandom_range(8);
      else if (r == 0) dsize = $urandom_range(blk - 1);
      else if (r == 1) dsize = '1;
      else dsize = $urandom_range(1, 4) * blk
                   + ((blk > 4) ? $urandom_range(3) : $urandom_range(blk - 1));
      push_le(dsize, 4);
      n = (dsize > DataCap) ? DataCap : dsize;
      repeat (n) file_bytes.push_back(sample_byte());
      repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
      // damage a header byte, or cut the file short
      if ($urandom_range(6) == 0) begin
         cut = $urandom_range(43);
         file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic restart);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.restart   <= restart;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // restart on the first word of a file, and now and then inside one
   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], (i == 0) || ($urandom_range(199) == 0));
   endtask

   // Result side: random stalls, and one long hold to back the block up
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && cycle_count >= HoldStart) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            stall = gap_len();
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      int sent;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.restart   <= 1'b0;
      calm = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // bad first byte
      file_bytes = '{8'hff};
      send_file();
      // zero length, then last WAVE character wrong
      file_bytes.delete();
      push_le(TagRiff, 4);
      push_le(32'h0, 4);
      push_le(TagWave ^ 32'h0100_0000, 4);
      send_file();
      // all-ones length, then fmt tag wrong at its first character
      file_bytes.delete();
      push_le(TagRiff, 4);
      push_le('1, 4);
      push_le(TagWave, 4);
      file_bytes.push_back(8'h00);
      send_file();

      sent = 0;
      while (sent < RandomBytes) begin
         calm = ($urandom_range(4) == 0);
         if ($urandom_range(9) == 0) begin
            file_bytes.delete();
            repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom));
         end else begin
            build_wav();
         end
         send_file();
         sent += file_bytes.size();
      end
      req_if.valid <= 1'b0;

      // wait until every expected word is seen and nothing is left in the block
      do @(posedge clock); while (pending_count != 0 || rsp_if.valid);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== wav_stream_parser_unit.f =====
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_req_if.sv
hw/rtl/wsp_rsp_if.sv
hw/rtl/wav_stream_parser_unit.sv
bench/wav_stream_parser_unit_check.sv
bench/wav_stream_parser_unit_test.sv
